// ----- rtl/core/abkf_pkg.sv -----
package abkf_pkg;

    // Fixed-point formats
    localparam int COV_FRAC_BITS = 40;
    localparam int VAL_W         = 32;
    localparam int COV_W         = 48;
    localparam int CFG_W         = 47;
    localparam int MS_W          = 16;
    localparam int CFG_IDX_W     = 2;

    // Shared multiplier: operand magnitude width and digit slicing
    localparam int OP_W   = 50;
    localparam int DIG_W  = 16;
    localparam int DIG_N  = 4;
    localparam int RES_W  = 62;
    localparam int SUM_W  = 64;

    // Shared divider: dividend is a covariance magnitude with fraction bits appended
    localparam int DIV_NUM_W = COV_W + COV_FRAC_BITS;

    // Milliseconds to seconds
    localparam int MS_DIV = 1000;
    localparam int MS_RND = 500;

    // dt = ms * floor(2^40 / 1000) + (ms * (2^40 mod 1000) + 500) / 1000,
    // the last quotient taken by reciprocal multiply (exact for a 26-bit dividend)
    localparam int DT_WHOLE_W = 31;
    localparam logic [DT_WHOLE_W-1:0] DT_WHOLE =
        DT_WHOLE_W'((64'd1 << COV_FRAC_BITS) / MS_DIV);
    localparam int DT_EXTRA_W = 10;
    localparam logic [DT_EXTRA_W-1:0] DT_EXTRA =
        DT_EXTRA_W'((64'd1 << COV_FRAC_BITS) % MS_DIV);
    localparam int DT_Y_W    = 26;
    localparam int DT_RCP_SH = 36;
    localparam int DT_RCP_W  = 27;
    localparam logic [DT_RCP_W-1:0] DT_RCP =
        DT_RCP_W'(((64'd1 << DT_RCP_SH) + MS_DIV - 1) / MS_DIV);

    // Register reset values
    localparam logic [CFG_W-1:0] RST_ANGLE_Q = 47'd1099511628;
    localparam logic [CFG_W-1:0] RST_BIAS_Q  = 47'd3298534883;
    localparam logic [CFG_W-1:0] RST_MEAS_R  = 47'd549755813888;
    localparam logic [CFG_W-1:0] RST_OBS_C   = CFG_W'(64'd1 << COV_FRAC_BITS);

    localparam logic signed [COV_W-1:0] COV_ONE = COV_W'(64'sd1 <<< COV_FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_Q = 2'd0,
        CFG_BIAS_Q  = 2'd1,
        CFG_MEAS_R  = 2'd2,
        CFG_OBS_C   = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DT,
        S_ANG,
        S_D00,
        S_D01,
        S_QB,
        S_PC0,
        S_PC1,
        S_E,
        S_K0,
        S_K1,
        S_K0E,
        S_K1E,
        S_K0P0,
        S_K0P1,
        S_K1P0,
        S_K1P1,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                   start;
        logic signed [OP_W-1:0] a;
        logic signed [OP_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                    done;
        logic signed [RES_W-1:0] res;
    } t_mul_rsp;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [COV_W-1:0]     den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [COV_W-1:0] quo;
    } t_div_rsp;

    // Clamp a wide sum to the 32-bit value range
    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-VAL_W:0] top;
        top = v[SUM_W-1:VAL_W-1];
        if (&top || ~|top) begin
            return v[VAL_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            return {1'b0, {(VAL_W-1){1'b1}}};
        end
    endfunction

    // Clamp a wide sum to the 48-bit covariance range
    function automatic logic signed [COV_W-1:0] sat_cov(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-COV_W:0] top;
        top = v[SUM_W-1:COV_W-1];
        if (&top || ~|top) begin
            return v[COV_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(COV_W-1){1'b0}}};
        end else begin
            return {1'b0, {(COV_W-1){1'b1}}};
        end
    endfunction

    // Magnitude of a covariance word; the most negative value maps to 2^47
    function automatic logic [COV_W-1:0] mag_cov(input logic signed [COV_W-1:0] v);
        return v[COV_W-1] ? COV_W'(-v) : COV_W'(v);
    endfunction

    // Signed gain from an unsigned quotient, clamped to the covariance range
    function automatic logic signed [COV_W-1:0] gain(input logic [COV_W-1:0] quo,
                                                     input logic ovf,
                                                     input logic neg,
                                                     input logic zero_den);
        logic sat;
        sat = ovf | quo[COV_W-1];
        if (zero_den) begin
            return '0;
        end else if (neg) begin
            return sat ? {1'b1, {(COV_W-1){1'b0}}} : -$signed(quo);
        end else begin
            return sat ? {1'b0, {(COV_W-1){1'b1}}} : $signed(quo);
        end
    endfunction

endpackage

// ----- rtl/core/abkf_in_if.sv -----
interface abkf_in_if;
    import abkf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] gyro_rate;
    logic signed [VAL_W-1:0] accel_angle;
    logic [MS_W-1:0]         step_ms;

    modport source (output valid, gyro_rate, accel_angle, step_ms, input ready);
    modport sink   (input valid, gyro_rate, accel_angle, step_ms, output ready);
endinterface

// ----- rtl/core/abkf_out_if.sv -----
interface abkf_out_if;
    import abkf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] angle_estimate;
    logic signed [VAL_W-1:0] rate_estimate;
    logic signed [VAL_W-1:0] bias_estimate;

    modport source (output valid, angle_estimate, rate_estimate, bias_estimate, input ready);
    modport sink   (input valid, angle_estimate, rate_estimate, bias_estimate, output ready);
endinterface

// ----- rtl/core/angle_bias_kalman_filter.sv -----
// Two-state Kalman filter for tilt angle and gyro bias.
// i_sample carries one beat per sensor sample: gyro_rate and accel_angle (Q16.16)
// and step_ms. o_result returns one beat per sample: angle, bias-corrected rate
// and bias, all Q16.16 and saturating.
// Noise settings and the observation coefficient are written through
// i_cfg_we / i_cfg_idx / i_cfg_data (unsigned Q7.40 values); the user must write
// them only while the filter is idle, as the block itself does not enforce it.
// The step time is scaled to seconds by constant multiply and reciprocal multiply.
// The rest of a sample runs on one shared 50x16 multiplier (13 products) and one
// shared radix-2 divider (two gains), stepped by the sequencer below. A new
// sample is accepted in the cycle after the previous result is loaded into the
// output register, so a new sample is not taken while one is being computed.
// i_sample.ready is high only while the sequencer is idle.
// The output register holds a finished beat while the receiver stalls; the
// next sample can then be accepted and computed, and its result waits until
// the held beat is taken.
// Synchronous reset restores default noise settings, zero angle and bias, and
// unit covariance diagonal, and drops any beat in flight.
module angle_bias_kalman_filter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [abkf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [abkf_pkg::CFG_W-1:0]      i_cfg_data,
    abkf_in_if.sink                         i_sample,
    abkf_out_if.source                      o_result
);
    import abkf_pkg::*;

    t_state r_state, n_state;

    // Configuration
    logic [CFG_W-1:0] r_q_angle, r_q_bias, r_meas_r, r_obs_c;

    // Filter state
    logic signed [VAL_W-1:0] r_angle, r_bias;
    logic signed [COV_W-1:0] r_paa, r_pab, r_pba, r_pbb;

    // Per-sample working registers
    logic signed [VAL_W-1:0] r_gyro, r_accel;
    logic [MS_W-1:0]         r_ms;
    logic [COV_W-1:0]        r_dt;
    logic [DT_Y_W-1:0]       r_dt_y;
    logic                    r_dt_step;
    logic signed [COV_W-1:0] r_pc0, r_pc1, r_e, r_k0, r_k1;
    logic signed [VAL_W:0]   r_err;
    logic                    r_busy;

    // Output register
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_angle, r_out_rate, r_out_bias;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic                    is_mul, is_div, op_done, out_free;
    logic signed [SUM_W-1:0] res_ext;

    // Step time scaling terms
    logic [MS_W+DT_WHOLE_W-1:0]              dt_whole;
    logic [DT_Y_W-1:0]                       dt_y;
    logic [DT_Y_W+DT_RCP_W-1:0]              dt_prod;
    logic [DT_Y_W+DT_RCP_W-DT_RCP_SH-1:0]    dt_frac;

    abkf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    abkf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign res_ext  = SUM_W'(mul_rsp.res);
    assign out_free = !r_out_valid || o_result.ready;
    assign op_done  = (is_mul && mul_rsp.done) || (is_div && div_rsp.done);

    // ms to Q8.40 seconds: whole part, then remainder by reciprocal
    assign dt_whole = (MS_W+DT_WHOLE_W)'(r_ms) * (MS_W+DT_WHOLE_W)'(DT_WHOLE);
    assign dt_y     = DT_Y_W'(r_ms) * DT_Y_W'(DT_EXTRA) + DT_Y_W'(MS_RND);
    assign dt_prod  = (DT_Y_W+DT_RCP_W)'(r_dt_y) * (DT_Y_W+DT_RCP_W)'(DT_RCP);
    assign dt_frac  = dt_prod[DT_Y_W+DT_RCP_W-1:DT_RCP_SH];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_sample.valid) n_state = S_DT;
            S_DT:   if (r_dt_step) n_state = S_ANG;
            S_ANG:  if (op_done) n_state = S_D00;
            S_D00:  if (op_done) n_state = S_D01;
            S_D01:  if (op_done) n_state = S_QB;
            S_QB:   if (op_done) n_state = S_PC0;
            S_PC0:  if (op_done) n_state = S_PC1;
            S_PC1:  if (op_done) n_state = S_E;
            S_E:    if (op_done) n_state = S_K0;
            S_K0:   if (op_done) n_state = S_K1;
            S_K1:   if (op_done) n_state = S_K0E;
            S_K0E:  if (op_done) n_state = S_K1E;
            S_K1E:  if (op_done) n_state = S_K0P0;
            S_K0P0: if (op_done) n_state = S_K0P1;
            S_K0P1: if (op_done) n_state = S_K1P0;
            S_K1P0: if (op_done) n_state = S_K1P1;
            S_K1P1: if (op_done) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Unit operands per step
    always_comb begin
        is_mul      = 1'b0;
        is_div      = 1'b0;
        mul_req.a   = '0;
        mul_req.b   = '0;
        div_req.num = '0;
        div_req.den = '0;
        unique case (r_state)
            S_ANG: begin
                is_mul    = 1'b1;
                mul_req.a = OP_W'(r_gyro) - OP_W'(r_bias);
                mul_req.b = $signed(OP_W'(r_dt));
            end
            S_D00: begin
                is_mul    = 1'b1;
                mul_req.a = $signed(OP_W'(r_q_angle)) - OP_W'(r_pab) - OP_W'(r_pba);
                mul_req.b = $signed(OP_W'(r_dt));
            end
            S_D01: begin
                is_mul    = 1'b1;
                mul_req.a = -OP_W'(r_pbb);
                mul_req.b = $signed(OP_W'(r_dt));
            end
            S_QB: begin
                is_mul    = 1'b1;
                mul_req.a = $signed(OP_W'(r_q_bias));
                mul_req.b = $signed(OP_W'(r_dt));
            end
            S_PC0: begin
                is_mul    = 1'b1;
                mul_req.a = $signed(OP_W'(r_obs_c));
                mul_req.b = OP_W'(r_paa);
            end
            S_PC1: begin
                is_mul    = 1'b1;
                mul_req.a = $signed(OP_W'(r_obs_c));
                mul_req.b = OP_W'(r_pab);
            end
            S_E: begin
                is_mul    = 1'b1;
                mul_req.a = $signed(OP_W'(r_obs_c));
                mul_req.b = OP_W'(r_pc0);
            end
            S_K0: begin
                is_div      = 1'b1;
                div_req.num = {mag_cov(r_pc0), {COV_FRAC_BITS{1'b0}}};
                div_req.den = mag_cov(r_e);
            end
            S_K1: begin
                is_div      = 1'b1;
                div_req.num = {mag_cov(r_pc1), {COV_FRAC_BITS{1'b0}}};
                div_req.den = mag_cov(r_e);
            end
            S_K0E: begin
                is_mul    = 1'b1;
                mul_req.a = OP_W'(r_k0);
                mul_req.b = OP_W'(r_err);
            end
            S_K1E: begin
                is_mul    = 1'b1;
                mul_req.a = OP_W'(r_k1);
                mul_req.b = OP_W'(r_err);
            end
            S_K0P0: begin
                is_mul    = 1'b1;
                mul_req.a = OP_W'(r_k0);
                mul_req.b = OP_W'(r_pc0);
            end
            S_K0P1: begin
                is_mul    = 1'b1;
                mul_req.a = OP_W'(r_k0);
                mul_req.b = OP_W'(r_pc1);
            end
            S_K1P0: begin
                is_mul    = 1'b1;
                mul_req.a = OP_W'(r_k1);
                mul_req.b = OP_W'(r_pc0);
            end
            S_K1P1: begin
                is_mul    = 1'b1;
                mul_req.a = OP_W'(r_k1);
                mul_req.b = OP_W'(r_pc1);
            end
            default: begin
            end
        endcase
        mul_req.start = is_mul && !r_busy;
        div_req.start = is_div && !r_busy;
    end

    assign i_sample.ready          = (r_state == S_IDLE);
    assign o_result.valid          = r_out_valid;
    assign o_result.angle_estimate = r_out_angle;
    assign o_result.rate_estimate  = r_out_rate;
    assign o_result.bias_estimate  = r_out_bias;

    // Sequencer and unit handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= 1'b0;
            r_dt_step   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DT) begin
                r_dt_step <= !r_dt_step;
            end
            if (op_done) begin
                r_busy <= 1'b0;
            end else if (mul_req.start || div_req.start) begin
                r_busy <= 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_angle <= RST_ANGLE_Q;
            r_q_bias  <= RST_BIAS_Q;
            r_meas_r  <= RST_MEAS_R;
            r_obs_c   <= RST_OBS_C;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ANGLE_Q: r_q_angle <= i_cfg_data;
                CFG_BIAS_Q:  r_q_bias  <= i_cfg_data;
                CFG_MEAS_R:  r_meas_r  <= i_cfg_data;
                CFG_OBS_C:   r_obs_c   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Filter state: predict, correct, covariance update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            r_bias  <= '0;
            r_paa   <= COV_ONE;
            r_pab   <= '0;
            r_pba   <= '0;
            r_pbb   <= COV_ONE;
        end else if (op_done) begin
            unique case (r_state)
                S_ANG:  r_angle <= sat_val(SUM_W'(r_angle) + res_ext);
                S_D00:  r_paa   <= sat_cov(SUM_W'(r_paa) + res_ext);
                S_D01: begin
                    r_pab <= sat_cov(SUM_W'(r_pab) + res_ext);
                    r_pba <= sat_cov(SUM_W'(r_pba) + res_ext);
                end
                S_QB:   r_pbb   <= sat_cov(SUM_W'(r_pbb) + res_ext);
                S_K0E:  r_angle <= sat_val(SUM_W'(r_angle) + res_ext);
                S_K1E:  r_bias  <= sat_val(SUM_W'(r_bias) + res_ext);
                S_K0P0: r_paa   <= sat_cov(SUM_W'(r_paa) - res_ext);
                S_K0P1: r_pab   <= sat_cov(SUM_W'(r_pab) - res_ext);
                S_K1P0: r_pba   <= sat_cov(SUM_W'(r_pba) - res_ext);
                S_K1P1: r_pbb   <= sat_cov(SUM_W'(r_pbb) - res_ext);
                default: begin
                end
            endcase
        end
    end

    // Working registers and result beat
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_sample.valid) begin
            r_gyro  <= i_sample.gyro_rate;
            r_accel <= i_sample.accel_angle;
            r_ms    <= i_sample.step_ms;
        end
        // step time: whole part first, rounded remainder second
        if (r_state == S_DT) begin
            if (!r_dt_step) begin
                r_dt   <= COV_W'(dt_whole);
                r_dt_y <= dt_y;
            end else begin
                r_dt <= r_dt + COV_W'(dt_frac);
            end
        end
        if (op_done) begin
            unique case (r_state)
                S_PC0: r_pc0 <= sat_cov(res_ext);
                S_PC1: r_pc1 <= sat_cov(res_ext);
                S_E:   r_e   <= sat_cov(SUM_W'($signed({1'b0, r_meas_r})) + res_ext);
                S_K0:  r_k0  <= gain(div_rsp.quo, div_rsp.ovf, r_pc0[COV_W-1] ^ r_e[COV_W-1],
                                     r_e == '0);
                S_K1: begin
                    r_k1  <= gain(div_rsp.quo, div_rsp.ovf, r_pc1[COV_W-1] ^ r_e[COV_W-1],
                                  r_e == '0);
                    // innovation against the predicted angle
                    r_err <= (VAL_W+1)'(r_accel) - (VAL_W+1)'(r_angle);
                end
                default: begin
                end
            endcase
        end
        if (r_state == S_DONE && out_free) begin
            r_out_angle <= r_angle;
            r_out_bias  <= r_bias;
            r_out_rate  <= sat_val(SUM_W'(r_gyro) - SUM_W'(r_bias));
        end
    end

endmodule

// ----- rtl/core/abkf_mul.sv -----
module abkf_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  abkf_pkg::t_mul_req  i_req,
    output abkf_pkg::t_mul_rsp  o_rsp
);
    import abkf_pkg::*;

    localparam int ACC_W = OP_W + DIG_N * DIG_W;
    localparam int PP_W  = OP_W + DIG_W;
    localparam int CNT_W = $clog2(DIG_N);

    logic [OP_W-1:0]          r_mag_a;
    logic [DIG_N*DIG_W-1:0]   r_mag_b;
    logic                     r_neg;
    logic [ACC_W-1:0]         r_acc;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_busy;
    logic                     r_fin;
    logic                     r_done;
    logic signed [RES_W-1:0]  r_res;

    logic [PP_W-1:0]  pp;
    logic [ACC_W-1:0] rnd;
    logic [RES_W-1:0] mag;

    // One 16-bit digit of b per cycle, accumulated with a right shift
    assign pp  = PP_W'(r_mag_a) * PP_W'(r_mag_b[DIG_W-1:0]);
    // Round to nearest, ties away from zero, on the magnitude
    assign rnd = r_acc + (ACC_W'(1) << (COV_FRAC_BITS - 1));
    assign mag = rnd[COV_FRAC_BITS +: RES_W];

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIG_N - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mag_a <= i_req.a[OP_W-1] ? OP_W'(-i_req.a) : OP_W'(i_req.a);
            r_mag_b <= (DIG_N*DIG_W)'(i_req.b[OP_W-1] ? OP_W'(-i_req.b) : OP_W'(i_req.b));
            r_neg   <= i_req.a[OP_W-1] ^ i_req.b[OP_W-1];
            r_acc   <= '0;
        end else if (r_busy) begin
            r_acc   <= (r_acc >> DIG_W) + (ACC_W'(pp) << (ACC_W - PP_W));
            r_mag_b <= r_mag_b >> DIG_W;
        end else if (r_fin) begin
            r_res <= r_neg ? -$signed(mag) : $signed(mag);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

// ----- rtl/core/abkf_div.sv -----
module abkf_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  abkf_pkg::t_div_req  i_req,
    output abkf_pkg::t_div_rsp  o_rsp
);
    import abkf_pkg::*;

    localparam int HI_W  = DIV_NUM_W - COV_W;
    localparam int CNT_W = $clog2(COV_W);

    logic [COV_W-1:0] r_rem;
    logic [COV_W-1:0] r_low;
    logic [COV_W-1:0] r_quo;
    logic [COV_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             r_ovf;

    logic [COV_W-1:0] num_hi;
    logic [COV_W:0]   trial;
    logic             qbit;

    // Quotient of 2^48 or more shows up before the loop
    assign num_hi = COV_W'(i_req.num[DIV_NUM_W-1 -: HI_W]);
    // Restoring step: one quotient bit per cycle
    assign trial  = {r_rem, r_low[COV_W-1]};
    assign qbit   = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(COV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ovf <= num_hi >= i_req.den;
            r_rem <= (num_hi >= i_req.den) ? '0 : num_hi;
            r_low <= i_req.num[COV_W-1:0];
            r_den <= i_req.den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= qbit ? COV_W'(trial - {1'b0, r_den}) : COV_W'(trial);
            r_low <= r_low << 1;
            r_quo <= {r_quo[COV_W-2:0], qbit};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.quo  = r_quo;

endmodule

// ----- sim/angle_bias_kalman_filter_tb.sv -----
`timescale 1ns / 100ps

module angle_bias_kalman_filter_tb;
    import abkf_pkg::*;

    localparam int           WATCHDOG_LIMIT = 20000;
    localparam int           DRAIN_CYCLES   = 300;
    localparam logic [63:0]  BIG_LIM        = 64'd1 << 62;
    localparam longint       V_MAX          = 64'sd2147483647;
    localparam longint       V_MIN          = -64'sd2147483648;
    localparam longint       C_MAX          = (64'sd1 <<< 47) - 1;
    localparam longint       C_MIN          = -(64'sd1 <<< 47);
    localparam logic [CFG_W-1:0] CFG_MAXV   = {CFG_W{1'b1}};

    typedef struct {
        logic signed [VAL_W-1:0] angle;
        logic signed [VAL_W-1:0] rate;
        logic signed [VAL_W-1:0] bias;
    } est_t;

    typedef struct {
        bit   typed;
        est_t est;
    } pend_t;

    typedef struct {
        logic signed [VAL_W-1:0] gyro;
        logic signed [VAL_W-1:0] accel;
        logic [MS_W-1:0]         ms;
        bit                      typed;
        est_t                    est;
    } row_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    abkf_in_if  smp ();
    abkf_out_if res ();

    angle_bias_kalman_filter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (smp.sink),
        .o_result   (res.source)
    );

    // Clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Filter shadow state and registers
    longint q_angle, q_bias, r_meas, c_obs;
    longint est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;

    est_t  est_q[$];
    pend_t pend_q[$];
    int    err_cnt;
    int    send_idle_pct;
    int    recv_stall_pct;
    int    hold_cycles;
    int    quiet_cycles;

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [63:0] magl(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Rounded Q.40 product, ties away from zero, magnitude capped at 2^62
    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] p;
        logic [63:0]  m;
        p = 128'(magl(a)) * 128'(magl(b)) + (128'd1 << (COV_FRAC_BITS - 1));
        p = p >> COV_FRAC_BITS;
        m = (p > 128'(BIG_LIM)) ? BIG_LIM : p[63:0];
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    // Truncated Q.40 quotient; zero divisor gives zero
    function automatic longint fx_div(longint n, longint d);
        logic [127:0] q;
        logic [63:0]  m;
        if (d == 0) return 0;
        q = (128'(magl(n)) << COV_FRAC_BITS) / 128'(magl(d));
        m = (q > 128'(BIG_LIM)) ? BIG_LIM : q[63:0];
        return ((n < 0) != (d < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic void filter_reset();
        q_angle = RST_ANGLE_Q; q_bias = RST_BIAS_Q;
        r_meas = RST_MEAS_R; c_obs = RST_OBS_C;
        est_angle = 0; est_bias = 0;
        p_aa = 64'sd1 <<< COV_FRAC_BITS; p_ab = 0; p_ba = 0; p_bb = p_aa;
    endfunction

    function automatic est_t filter_step(longint g, longint a, logic [MS_W-1:0] ms);
        longint dt, d00, d01, pc0, pc1, e, k0, k1, er;
        est_t   r;
        dt = longint'(((128'(ms) << COV_FRAC_BITS) + MS_RND) / MS_DIV);
        est_angle = clampl(est_angle + fx_mul(g - est_bias, dt), V_MIN, V_MAX);
        d00 = q_angle - p_ab - p_ba;
        d01 = -p_bb;
        p_aa = clampl(p_aa + fx_mul(d00, dt), C_MIN, C_MAX);
        p_ab = clampl(p_ab + fx_mul(d01, dt), C_MIN, C_MAX);
        p_ba = clampl(p_ba + fx_mul(d01, dt), C_MIN, C_MAX);
        p_bb = clampl(p_bb + fx_mul(q_bias, dt), C_MIN, C_MAX);
        pc0 = clampl(fx_mul(c_obs, p_aa), C_MIN, C_MAX);
        pc1 = clampl(fx_mul(c_obs, p_ab), C_MIN, C_MAX);
        e   = clampl(r_meas + fx_mul(c_obs, pc0), C_MIN, C_MAX);
        k0  = clampl(fx_div(pc0, e), C_MIN, C_MAX);
        k1  = clampl(fx_div(pc1, e), C_MIN, C_MAX);
        er  = a - est_angle;
        est_angle = clampl(est_angle + fx_mul(k0, er), V_MIN, V_MAX);
        est_bias  = clampl(est_bias + fx_mul(k1, er), V_MIN, V_MAX);
        r.rate  = 32'(clampl(g - est_bias, V_MIN, V_MAX));
        p_aa = clampl(p_aa - fx_mul(k0, pc0), C_MIN, C_MAX);
        p_ab = clampl(p_ab - fx_mul(k0, pc1), C_MIN, C_MAX);
        p_ba = clampl(p_ba - fx_mul(k1, pc0), C_MIN, C_MAX);
        p_bb = clampl(p_bb - fx_mul(k1, pc1), C_MIN, C_MAX);
        r.angle = 32'(est_angle);
        r.bias  = 32'(est_bias);
        return r;
    endfunction

    // Register write, only while idle
    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        case (idx)
            CFG_ANGLE_Q: q_angle = longint'(val);
            CFG_BIAS_Q:  q_bias  = longint'(val);
            CFG_MEAS_R:  r_meas  = longint'(val);
            CFG_OBS_C:   c_obs   = longint'(val);
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(logic [CFG_W-1:0] qa, logic [CFG_W-1:0] qb,
                            logic [CFG_W-1:0] rm, logic [CFG_W-1:0] co);
        while (est_q.size() != 0 || pend_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(CFG_ANGLE_Q, qa);
        write_reg(CFG_BIAS_Q, qb);
        write_reg(CFG_MEAS_R, rm);
        write_reg(CFG_OBS_C, co);
    endtask

    // Offer one beat, holding it until accepted
    task automatic send_sample(logic signed [VAL_W-1:0] g, logic signed [VAL_W-1:0] a,
                               logic [MS_W-1:0] ms, bit typed, est_t e);
        pend_t p;
        p.typed = typed; p.est = e;
        pend_q.push_back(p);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            smp.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp.valid <= 1'b1;
        smp.gyro_rate <= g; smp.accel_angle <= a; smp.step_ms <= ms;
        @(posedge i_clk);
        while (!smp.ready) @(posedge i_clk);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        smp.valid <= 1'b0;
    endtask

    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed(32'($urandom_range(8192))) - 32'sd4096;
            2: return $signed(32'($urandom_range(6553600))) - 32'sd3276800;
            default: return $signed(32'($urandom_range(655360))) - 32'sd327680;
        endcase
    endfunction

    function automatic logic [MS_W-1:0] rand_ms();
        case ($urandom_range(9))
            0: return MS_W'($urandom);
            1: return '0;
            default: return MS_W'($urandom_range(50));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_cfg();
        case ($urandom_range(2))
            0: return CFG_W'({$urandom, $urandom});
            1: return CFG_W'($urandom_range(1 << 20)) << $urandom_range(30);
            default: return CFG_W'($urandom) << 8;
        endcase
    endfunction

    // Receiver: random stall, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            res.ready <= 1'b0;
        end else begin
            res.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on accepted samples, check accepted results
    always @(posedge i_clk) begin
        pend_t p;
        est_t  e, got;
        if (i_rst_n) begin
            if (smp.valid && smp.ready) begin
                if (pend_q.size() == 0) begin
                    $display("%0t: sample accepted with nothing offered", $time);
                    err_cnt++;
                end else begin
                    p = pend_q.pop_front();
                    e = filter_step(smp.gyro_rate, smp.accel_angle, smp.step_ms);
                    est_q.push_back(p.typed ? p.est : e);
                end
            end
            if (res.valid && res.ready) begin
                got.angle = res.angle_estimate;
                got.rate  = res.rate_estimate;
                got.bias  = res.bias_estimate;
                if (est_q.size() == 0) begin
                    $display("%0t: unexpected result %h %h %h", $time,
                             got.angle, got.rate, got.bias);
                    err_cnt++;
                end else begin
                    e = est_q.pop_front();
                    if (got.angle !== e.angle) begin
                        $display("%0t: angle exp %h got %h", $time, e.angle, got.angle);
                        err_cnt++;
                    end
                    if (got.rate !== e.rate) begin
                        $display("%0t: rate exp %h got %h", $time, e.rate, got.rate);
                        err_cnt++;
                    end
                    if (got.bias !== e.bias) begin
                        $display("%0t: bias exp %h got %h", $time, e.bias, got.bias);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((smp.valid && smp.ready) || (res.valid && res.ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        row_t rows[];
        est_t none;
        int   ph;
        i_clk = 1'b0; i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        smp.valid = 1'b0; smp.gyro_rate = '0; smp.accel_angle = '0; smp.step_ms = '0;
        res.ready = 1'b0;
        err_cnt = 0; hold_cycles = 0; quiet_cycles = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        none = '{0, 0, 0};
        filter_reset();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero error keeps angle and bias at zero right after reset
        rows = '{
            '{32'sd0, 32'sd0, 16'd0, 1, '{32'sd0, 32'sd0, 32'sd0}},
            '{32'h7fffffff, 32'sd0, 16'd0, 1, '{32'sd0, 32'h7fffffff, 32'sd0}},
            '{32'h80000000, 32'sd0, 16'd0, 1, '{32'sd0, 32'h80000000, 32'sd0}},
            '{32'sd0, 32'h7fffffff, 16'd0, 0, none},
            '{32'sd0, 32'h80000000, 16'd0, 0, none},
            '{32'h7fffffff, 32'h7fffffff, 16'hffff, 0, none},
            '{32'h80000000, 32'h80000000, 16'hffff, 0, none},
            '{32'sd65536, 32'sd0, 16'd1, 0, none},
            '{32'sd65536, 32'sd655360, 16'd1000, 0, none},
            '{32'h55555555, 32'haaaaaaaa, 16'h5555, 0, none},
            '{32'haaaaaaaa, 32'h55555555, 16'haaaa, 0, none},
            '{-32'sd65536, 32'sd0, 16'd10, 0, none}
        };
        foreach (rows[i])
            send_sample(rows[i].gyro, rows[i].accel, rows[i].ms, rows[i].typed, rows[i].est);
        drop_valid();

        // Zero divisor: no measurement noise and no observation
        set_regs(RST_ANGLE_Q, RST_BIAS_Q, '0, '0);
        send_sample(32'sd65536, 32'sd1000, 16'd5, 0, none);
        send_sample(32'sd0, 32'sd99999, 16'd0, 0, none);
        drop_valid();
        // Register extremes
        set_regs(CFG_MAXV, CFG_MAXV, CFG_MAXV, CFG_MAXV);
        send_sample(32'h7fffffff, 32'h80000000, 16'hffff, 0, none);
        send_sample(32'sd12345, 32'sd54321, 16'd20, 0, none);
        drop_valid();

        // Random phases over several settings and idle mixes
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_regs(RST_ANGLE_Q, RST_BIAS_Q, RST_MEAS_R, RST_OBS_C);
                1: set_regs(rand_cfg(), rand_cfg(), rand_cfg(), rand_cfg());
                2: set_regs('0, '0, RST_MEAS_R, RST_OBS_C);
                3: set_regs(RST_ANGLE_Q, RST_BIAS_Q, CFG_MAXV, RST_OBS_C);
                4: set_regs(rand_cfg(), rand_cfg(), '0, rand_cfg());
                default: set_regs(RST_ANGLE_Q, RST_BIAS_Q, RST_MEAS_R, RST_OBS_C);
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            // Long receiver hold-off so the block backs up into its input
            if (ph == 5) begin
                send_idle_pct = 0;
                @(negedge i_clk);
                hold_cycles = 3000;
            end
            repeat (100) send_sample(rand_value(), rand_value(), rand_ms(), 0, none);
            drop_valid();
        end

        // Drain
        while (est_q.size() != 0 || pend_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
